FILE: hw/rtl/nkms_pkg.sv
package nkms_pkg;

	localparam int KEY_W   = 31;
	localparam int TOTAL_W = 20;
	localparam int OCC_W   = 11;
	localparam logic [TOTAL_W-1:0] TOTAL_MOD = 20'd1000000;

	// Division of a key distance by TOTAL_MOD through a reciprocal multiply.
	localparam int QUOT_W      = 12;
	localparam int RECIP_W     = 32;
	localparam int RECIP_SHIFT = 51;
	localparam logic [RECIP_W-1:0] MOD_RECIP = 32'd2251799814;

	typedef enum logic [1:0] {
		OUT_STORED  = 2'd0,
		OUT_MATCHED = 2'd1,
		OUT_DROPPED = 2'd2
	} outcome_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DECIDE,
		ST_SHIFT,
		ST_QUOT,
		ST_REM,
		ST_ACCUM,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic decide;
		logic shift;
		logic commit;
		logic quot;
		logic rem;
		logic accum;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_end;
		logic shift_end;
		logic need_shift;
	} ctrl_sts_t;

endpackage

FILE: hw/rtl/nkms_if.sv
interface nkms_in_if;
	import nkms_pkg::*;
	logic             valid;
	logic             ready;
	logic             side;
	logic [KEY_W-1:0] key_value;
	modport source (output valid, side, key_value, input ready);
	modport sink   (input valid, side, key_value, output ready);
endinterface

interface nkms_out_if;
	import nkms_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         outcome;
	logic [KEY_W-1:0]   matched_key;
	logic [KEY_W-1:0]   distance;
	logic [TOTAL_W-1:0] running_total;
	logic [OCC_W-1:0]   occupancy;
	modport source (output valid, outcome, matched_key, distance, running_total, occupancy,
		input ready);
	modport sink   (input valid, outcome, matched_key, distance, running_total, occupancy,
		output ready);
endinterface

FILE: hw/rtl/nkms_ram.sv
module nkms_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hw/rtl/nkms_ctrl.sv
module nkms_ctrl
	import nkms_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_READ;
			ST_READ:   if (sts.scan_end) state_d = ST_DECIDE;
			ST_DECIDE: state_d = sts.need_shift ? ST_SHIFT : ST_QUOT;
			ST_SHIFT:  if (sts.shift_end) state_d = ST_QUOT;
			ST_QUOT:   state_d = ST_REM;
			ST_REM:    state_d = ST_ACCUM;
			ST_ACCUM:  state_d = ST_DONE;
			ST_DONE:   if (out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_READ:   cmd.rd = 1'b1;
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				cmd.commit = !sts.need_shift;
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				cmd.commit = sts.shift_end;
			end
			ST_QUOT:   cmd.quot = 1'b1;
			ST_REM:    cmd.rem = 1'b1;
			ST_ACCUM:  cmd.accum = 1'b1;
			ST_DONE:   out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule

FILE: hw/rtl/nkms_dp.sv
module nkms_dp
	import nkms_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_cmd_t          cmd,
	output ctrl_sts_t          sts,
	input  logic               in_side,
	input  logic [KEY_W-1:0]   in_key,
	output logic [1:0]         outcome,
	output logic [KEY_W-1:0]   matched_key,
	output logic [KEY_W-1:0]   distance,
	output logic [TOTAL_W-1:0] running_total,
	output logic [OCC_W-1:0]   occupancy
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic             side_q;
	logic [KEY_W-1:0] key_q;
	logic [CW-1:0]    count_q;
	logic             held_q;
	logic [TOTAL_W-1:0] sum_q;
	logic             insert_q, full_q;

	// Linear scan: raddr runs one address ahead of the registered read data.
	logic [CW-1:0]    raddr_q;
	logic [CW-1:0]    idx_q;
	logic             rvalid_q;
	logic [KEY_W-1:0] rdata;
	logic [CW-1:0]    pos_q;
	logic [KEY_W-1:0] lo_key_q, hi_key_q;
	logic             have_lo_q, have_hi_q;

	logic [CW-1:0]    sh_q;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [KEY_W-1:0] wdata;
	logic [AW-1:0]    raddr;

	logic             hit;
	logic [KEY_W-1:0] dlo, dhi, mk, gap;
	logic             pick_lo;
	logic [TOTAL_W:0] sum_w;

	logic [KEY_W+RECIP_W-1:0] prod;
	logic [QUOT_W-1:0]        quot_q;
	logic [TOTAL_W-1:0]       rem_q;

	assign raddr = raddr_q[AW-1:0];
	nkms_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	// For insertion the scan looks for the first key above; for a match the first key not below.
	assign hit = insert_q ? (rdata > key_q) : (rdata >= key_q);
	assign sts.scan_end = rvalid_q && (hit || idx_q + 1'b1 >= count_q) || count_q == '0 ||
		insert_q && full_q;

	assign dlo = key_q - lo_key_q;
	assign dhi = hi_key_q - key_q;
	assign pick_lo = have_lo_q && (!have_hi_q || (hi_key_q != key_q && dlo <= dhi));
	assign mk = pick_lo ? lo_key_q : hi_key_q;
	assign gap = (mk >= key_q) ? mk - key_q : key_q - mk;
	assign sts.need_shift = insert_q ? (!full_q && pos_q < count_q)
		: (pos_q - CW'(pick_lo) + 1'b1 < count_q);
	assign sts.shift_end = insert_q ? (sh_q == pos_q) : (sh_q + 1'b1 >= count_q);

	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = key_q;
		if (cmd.decide && insert_q && !full_q && !sts.need_shift) begin
			we = 1'b1;
			waddr = pos_q[AW-1:0];
		end else if (cmd.shift && insert_q) begin
			we = rvalid_q;
			waddr = sh_q[AW-1:0];
			wdata = (sh_q == pos_q) ? key_q : rdata;
		end else if (cmd.shift) begin
			we = rvalid_q;
			waddr = AW'(sh_q - 1'b1);
			wdata = rdata;
		end
	end

	assign prod = (KEY_W+RECIP_W)'(distance) * (KEY_W+RECIP_W)'(MOD_RECIP);
	assign sum_w = {1'b0, sum_q} + {1'b0, rem_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			held_q <= 1'b0;
			sum_q <= '0;
		end else begin
			if (cmd.commit) begin
				if (insert_q) begin
					if (!full_q) begin
						count_q <= count_q + 1'b1;
						held_q <= side_q;
					end
				end else begin
					count_q <= count_q - 1'b1;
				end
			end
			if (cmd.accum) begin
				sum_q <= (sum_w >= {1'b0, TOTAL_MOD}) ? TOTAL_W'(sum_w - {1'b0, TOTAL_MOD})
					: sum_w[TOTAL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		rvalid_q <= 1'b0;
		if (cmd.load) begin
			side_q <= in_side;
			key_q <= in_key;
			insert_q <= count_q == '0 || in_side == held_q;
			full_q <= count_q >= CW'(CAPACITY);
			raddr_q <= '0;
			idx_q <= '0;
			pos_q <= count_q;
			have_lo_q <= 1'b0;
			have_hi_q <= 1'b0;
		end else if (cmd.rd) begin
			rvalid_q <= raddr_q < count_q;
			raddr_q <= raddr_q + 1'b1;
			if (rvalid_q) begin
				idx_q <= idx_q + 1'b1;
				if (hit) begin
					pos_q <= idx_q;
					have_hi_q <= 1'b1;
					hi_key_q <= rdata;
				end else begin
					have_lo_q <= 1'b1;
					lo_key_q <= rdata;
				end
			end
		end else if (cmd.decide) begin
			outcome <= insert_q ? (full_q ? OUT_DROPPED : OUT_STORED) : OUT_MATCHED;
			matched_key <= insert_q ? '0 : mk;
			distance <= insert_q ? '0 : gap;
			if (insert_q) begin
				sh_q <= count_q;
				raddr_q <= count_q - 1'b1;
			end else begin
				sh_q <= pos_q - CW'(pick_lo);
				raddr_q <= pos_q - CW'(pick_lo) + 1'b1;
			end
		end else if (cmd.shift) begin
			if (insert_q) begin
				if (rvalid_q) begin
					sh_q <= sh_q - 1'b1;
				end
				raddr_q <= raddr_q - 1'b1;
				rvalid_q <= 1'b1;
			end else begin
				rvalid_q <= 1'b1;
				sh_q <= sh_q + 1'b1;
				raddr_q <= raddr_q + 1'b1;
			end
		end else if (cmd.quot) begin
			quot_q <= prod[RECIP_SHIFT +: QUOT_W];
		end else if (cmd.rem) begin
			rem_q <= TOTAL_W'(distance - KEY_W'(quot_q) * KEY_W'(TOTAL_MOD));
		end
		if (cmd.rd && sts.scan_end) begin
			rvalid_q <= 1'b0;
		end
	end

	assign running_total = sum_q;
	assign occupancy = OCC_W'(count_q);
endmodule

FILE: hw/rtl/nearest_key_match_store.sv
// Keeps up to CAPACITY keys of one side in ascending order in a RAM with one read port and
// matches each opposite-side item against the nearest held key (ties to the smaller key).
// For each item, between its acceptance and its result, a linear scan of the RAM finds the
// position, a second pass, where needed, shifts the entries above it one per cycle to open
// or close a gap, and the quotient, remainder and accumulate states fold the distance into
// the running total modulo 1000000. The result is held until the sink takes it, and the
// next item can be accepted in the cycle after that. Exactly one result item follows each
// input item.
module nearest_key_match_store
	import nkms_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input logic         clk,
	input logic         arst_n,
	nkms_in_if.sink     in_ch,
	nkms_out_if.source  out_ch
);
	ctrl_cmd_t  cmd;
	ctrl_sts_t  sts;
	logic [1:0] outcome;

	nkms_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts, .cmd
	);

	nkms_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.in_side(in_ch.side), .in_key(in_ch.key_value),
		.outcome,
		.matched_key(out_ch.matched_key),
		.distance(out_ch.distance),
		.running_total(out_ch.running_total),
		.occupancy(out_ch.occupancy)
	);

	assign out_ch.outcome = outcome;
endmodule

FILE: tb/sv/tb_nearest_key_match_store.sv
module tb_nearest_key_match_store;
	import nkms_pkg::*;

	localparam int CAP = 1024;
	localparam longint CYCLE_LIMIT = 12000000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		outcome_t         outcome;
		logic [KEY_W-1:0] matched_key;
		logic [KEY_W-1:0] distance;
		logic [TOTAL_W-1:0] running_total;
		logic [OCC_W-1:0] occupancy;
	} match_result_t;

	logic clk;
	logic arst_n;
	nkms_in_if  in_if();
	nkms_out_if out_if();

	nearest_key_match_store #(.CAPACITY(CAP)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_if),
		.out_ch(out_if)
	);

	logic [KEY_W-1:0] held_keys[$];
	logic             held_side;
	logic [TOTAL_W-1:0] dist_total;
	match_result_t    pending_results[$];

	int     send_idle_pct;
	int     recv_idle_pct;
	int     hold_reqs;
	int     hold_seen;
	int     hold_left;
	int     errors;
	longint cycles;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("nearest_key_match_store: mismatch");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		match_result_t e;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result outcome=%0d key=%0d", $time,
					out_if.outcome, out_if.matched_key);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (out_if.outcome !== e.outcome) begin
					$display("%0t: outcome expected %0d actual %0d", $time, e.outcome,
						out_if.outcome);
					errors++;
				end
				if (out_if.matched_key !== e.matched_key) begin
					$display("%0t: matched_key expected %0d actual %0d", $time,
						e.matched_key, out_if.matched_key);
					errors++;
				end
				if (out_if.distance !== e.distance) begin
					$display("%0t: distance expected %0d actual %0d", $time, e.distance,
						out_if.distance);
					errors++;
				end
				if (out_if.running_total !== e.running_total) begin
					$display("%0t: running_total expected %0d actual %0d", $time,
						e.running_total, out_if.running_total);
					errors++;
				end
				if (out_if.occupancy !== e.occupancy) begin
					$display("%0t: occupancy expected %0d actual %0d", $time,
						e.occupancy, out_if.occupancy);
					errors++;
				end
			end
		end
	end

	function automatic match_result_t predict_match(logic s, logic [KEY_W-1:0] k);
		match_result_t r;
		int p;
		int sel;
		logic [KEY_W-1:0] dlo;
		logic [KEY_W-1:0] dhi;
		r.matched_key = '0;
		r.distance = '0;
		if (held_keys.size() == 0 || s == held_side) begin
			if (held_keys.size() >= CAP) begin
				r.outcome = OUT_DROPPED;
			end else begin
				p = 0;
				while (p < held_keys.size() && held_keys[p] <= k) p++;
				held_keys.insert(p, k);
				held_side = s;
				r.outcome = OUT_STORED;
			end
		end else begin
			p = 0;
			while (p < held_keys.size() && held_keys[p] < k) p++;
			if (p < held_keys.size() && held_keys[p] == k) begin
				sel = p;
			end else if (p == 0) begin
				sel = 0;
			end else if (p >= held_keys.size()) begin
				sel = p - 1;
			end else begin
				dlo = k - held_keys[p-1];
				dhi = held_keys[p] - k;
				sel = (dlo <= dhi) ? p - 1 : p;
			end
			r.matched_key = held_keys[sel];
			r.distance = (r.matched_key >= k) ? r.matched_key - k : k - r.matched_key;
			held_keys.delete(sel);
			dist_total = TOTAL_W'((64'(dist_total) + 64'(r.distance)) % 64'd1000000);
			r.outcome = OUT_MATCHED;
		end
		r.running_total = dist_total;
		r.occupancy = OCC_W'(held_keys.size());
		return r;
	endfunction

	task automatic send_item(logic s, logic [KEY_W-1:0] k);
		if ($urandom_range(99) < send_idle_pct) begin
			in_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_if.valid <= 1'b1;
		in_if.side <= s;
		in_if.key_value <= k;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
		pending_results.push_back(predict_match(s, k));
	endtask

	task automatic wait_drained();
		in_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(3))
			0: return KEY_W'($urandom);
			1, 2: return KEY_W'($urandom_range(63));
			default: return KEY_W'(31'h7FFF_FFFF - $urandom_range(63));
		endcase
	endfunction

	task automatic test_directed();
		send_item(1'b1, 31'd100);
		send_item(1'b1, 31'd100);
		send_item(1'b1, 31'd200);
		send_item(1'b0, 31'd100);
		send_item(1'b0, 31'd150);
		send_item(1'b0, 31'd5);
		send_item(1'b0, 31'd0);
		send_item(1'b0, 31'h7FFF_FFFF);
		send_item(1'b1, 31'h7FFF_FFFF);
		send_item(1'b0, 31'd0);
		send_item(1'b1, 31'd0);
		send_item(1'b1, 31'd10);
		send_item(1'b0, 31'd5);
		send_item(1'b0, 31'd5);
		send_item(1'b0, 31'h2AAA_AAAA);
		send_item(1'b1, 31'h5555_5555);
		send_item(1'b1, 31'd300);
		send_item(1'b0, 31'd400);
		send_item(1'b0, 31'd20);
		wait_drained();
	endtask

	task automatic test_random(int n);
		logic s;
		for (int i = 0; i < n; i++) begin
			if (held_keys.size() > 24)
				s = ($urandom_range(3) == 0) ? held_side : ~held_side;
			else if (held_keys.size() < 3)
				s = ($urandom_range(3) == 0) ? ~held_side : held_side;
			else
				s = 1'($urandom_range(1));
			send_item(s, pick_key());
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_reqs++;
		for (int i = 0; i < 30; i++) send_item(1'($urandom_range(1)), pick_key());
		wait_drained();
	endtask

	task automatic test_full_store();
		logic s;
		s = held_keys.size() == 0 ? 1'b0 : held_side;
		while (held_keys.size() < CAP) send_item(s, KEY_W'($urandom));
		send_item(s, 31'h7FFF_FFFF);
		send_item(s, 31'd0);
		send_item(~s, KEY_W'($urandom));
		send_item(s, 31'd0);
		send_item(s, 31'd1);
		wait_drained();
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		hold_reqs = 0;
		held_side = 1'b0;
		dist_total = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n <= 1'b0;
		in_if.valid <= 1'b0;
		in_if.side <= 1'b0;
		in_if.key_value <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 30;
		recv_idle_pct = 63;
		test_directed();
		test_random(110);
		test_backpressure();
		send_idle_pct = 63;
		recv_idle_pct = 30;
		test_random(110);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(110);
		test_full_store();

		repeat (50) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("nearest_key_match_store: match");
		end else begin
			$display("nearest_key_match_store: mismatch");
		end
		$finish;
	end

endmodule
